// ===== sv/assert_macros.svh =====
// Assertion macros shared by the I2C register-read core.
// Each macro expects a signal named clock in the enclosing module; ASSERT_CLK also expects reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ===== sv/i2cmrr_pkg.sv =====
// Package for the I2C master register-read core.
// Holds the sequencer phase encoding, status codes, register indexes and shared structs.
`timescale 1ns / 1ps
`default_nettype none

package i2cmrr_pkg;

   // Sequencer phases, one-hot.
   typedef enum logic [11:0] {
      PH_IDLE      = 12'b0000_0000_0001,
      PH_TX_ADDR   = 12'b0000_0000_0010,
      PH_ACK_ADDR  = 12'b0000_0000_0100,
      PH_TX_REG    = 12'b0000_0000_1000,
      PH_ACK_REG   = 12'b0000_0001_0000,
      PH_STOP_MID  = 12'b0000_0010_0000,
      PH_RESTART   = 12'b0000_0100_0000,
      PH_TX_RADDR  = 12'b0000_1000_0000,
      PH_ACK_RADDR = 12'b0001_0000_0000,
      PH_RX        = 12'b0010_0000_0000,
      PH_MACK      = 12'b0100_0000_0000,
      PH_STOP_END  = 12'b1000_0000_0000
   } phase_type;

   // Completion status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ADDR_NACK  = 2'd1,
      ST_REG_NACK   = 2'd2,
      ST_RADDR_NACK = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEVICE_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_REGISTER_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_READ_LENGTH      = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] DEVICE_ADDRESS_RESET   = 8'd238;
   localparam logic [7:0] REGISTER_ADDRESS_RESET = 8'd0;
   localparam logic [5:0] READ_LENGTH_RESET      = 6'd1;

   typedef struct packed {
      logic [7:0] device_address_byte;
      logic [7:0] register_address;
      logic [5:0] read_length;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic [5:0] bytes_left;
      status_type result_status;
   } seq_state_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_pull_low;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       done_res;
      status_type status;
      logic       busy_res;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/i2cmrr_csr.sv =====
// Configuration registers of the I2C master register-read core.
// Depends on i2cmrr_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module i2cmrr_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [1:0]        wr_index,
   input  wire logic [7:0]        wr_data,
   output i2cmrr_pkg::cfg_type    cfg
);
   import i2cmrr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write; an index beyond the register list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DEVICE_ADDRESS:   cfg_in.device_address_byte = wr_data;
            CSR_REGISTER_ADDRESS: cfg_in.register_address    = wr_data;
            CSR_READ_LENGTH:      cfg_in.read_length         = wr_data[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address_byte <= DEVICE_ADDRESS_RESET;
         cfg_ff.register_address    <= REGISTER_ADDRESS_RESET;
         cfg_ff.read_length         <= READ_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/i2cmrr_step.sv =====
// Next-state and bus-level logic for one SCL half-phase of the register-read sequence.
// Purely combinational; depends on i2cmrr_pkg for the phase, state and result types.
`timescale 1ns / 1ps
`default_nettype none

module i2cmrr_step #(
   parameter int MAX_READ_LEN = 32
) (
   input  wire logic                       kind,
   input  wire logic                       sda_in,
   input  wire i2cmrr_pkg::cfg_type        cfg,
   input  wire i2cmrr_pkg::seq_state_type  cur,
   output i2cmrr_pkg::seq_state_type       nxt,
   output i2cmrr_pkg::result_type          res
);
   import i2cmrr_pkg::*;

   localparam logic [7:0] MaxLen = 8'(MAX_READ_LEN);

   logic       half;
   logic       last_slot;
   logic [3:0] bc_inc;
   logic [7:0] rx_shift;
   logic [5:0] bl_dec;
   logic [5:0] start_len;

   assign half      = cur.bit_count[0];
   assign last_slot = (cur.bit_count == 4'hF);
   assign bc_inc    = cur.bit_count + 4'd1;
   assign rx_shift  = {cur.shift_reg[6:0], sda_in};
   assign bl_dec    = cur.bytes_left - 6'd1;

   // Length latched at start: zero means one, long requests are clamped.
   always_comb begin
      if (cfg.read_length == 6'd0) begin
         start_len = 6'd1;
      end else if ({2'b00, cfg.read_length} > MaxLen) begin
         start_len = MaxLen[5:0];
      end else begin
         start_len = cfg.read_length;
      end
   end

   // Phase sequencing; idle bus levels unless a phase drives otherwise.
   always_comb begin
      nxt              = cur;
      res.scl_out      = 1'b1;
      res.sda_pull_low = 1'b0;
      res.data_valid   = 1'b0;
      res.data_byte    = 8'd0;
      res.done_res     = 1'b0;
      res.status       = ST_OK;

      case (cur.phase)
         PH_IDLE: begin
            if (kind) begin
               nxt.bytes_left    = start_len;
               nxt.result_status = ST_OK;
               res.sda_pull_low  = 1'b1;
               nxt.shift_reg     = cfg.device_address_byte;
               nxt.bit_count     = 4'd0;
               nxt.phase         = PH_TX_ADDR;
            end
         end

         PH_TX_ADDR, PH_TX_REG, PH_TX_RADDR: begin
            res.scl_out      = half;
            res.sda_pull_low = ~cur.shift_reg[7];
            if (half) begin
               nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
            end
            nxt.bit_count = bc_inc;
            if (last_slot) begin
               case (cur.phase)
                  PH_TX_ADDR: nxt.phase = PH_ACK_ADDR;
                  PH_TX_REG:  nxt.phase = PH_ACK_REG;
                  default:    nxt.phase = PH_ACK_RADDR;
               endcase
            end
         end

         PH_ACK_ADDR, PH_ACK_REG, PH_ACK_RADDR: begin
            res.scl_out   = half;
            nxt.bit_count = 4'd1;
            if (half) begin
               nxt.bit_count = 4'd0;
               if (sda_in) begin
                  // Missing acknowledge: record which byte failed and stop the bus.
                  case (cur.phase)
                     PH_ACK_ADDR: nxt.result_status = ST_ADDR_NACK;
                     PH_ACK_REG:  nxt.result_status = ST_REG_NACK;
                     default:     nxt.result_status = ST_RADDR_NACK;
                  endcase
                  nxt.phase = PH_STOP_END;
               end else begin
                  case (cur.phase)
                     PH_ACK_ADDR: begin
                        nxt.shift_reg = cfg.register_address;
                        nxt.phase     = PH_TX_REG;
                     end
                     PH_ACK_REG: begin
                        nxt.phase = PH_STOP_MID;
                     end
                     default: begin
                        nxt.shift_reg = 8'd0;
                        nxt.phase     = PH_RX;
                     end
                  endcase
               end
            end
         end

         PH_STOP_MID, PH_STOP_END: begin
            if (cur.bit_count == 4'd0) begin
               res.scl_out      = 1'b0;
               res.sda_pull_low = 1'b1;
               nxt.bit_count    = 4'd1;
            end else if (cur.bit_count == 4'd1) begin
               res.sda_pull_low = 1'b1;
               nxt.bit_count    = 4'd2;
            end else begin
               nxt.bit_count = 4'd0;
               if (cur.phase == PH_STOP_MID) begin
                  nxt.phase = PH_RESTART;
               end else begin
                  res.done_res = 1'b1;
                  res.status   = cur.result_status;
                  nxt.phase    = PH_IDLE;
               end
            end
         end

         PH_RESTART: begin
            res.sda_pull_low = 1'b1;
            nxt.shift_reg    = cfg.device_address_byte + 8'd1;
            nxt.bit_count    = 4'd0;
            nxt.phase        = PH_TX_RADDR;
         end

         PH_RX: begin
            res.scl_out = half;
            if (half) begin
               nxt.shift_reg = rx_shift;
            end
            nxt.bit_count = bc_inc;
            if (last_slot) begin
               res.data_valid = 1'b1;
               res.data_byte  = rx_shift;
               nxt.phase      = PH_MACK;
            end
         end

         PH_MACK: begin
            // Master acknowledges every byte but the last one.
            res.scl_out      = half;
            res.sda_pull_low = (cur.bytes_left > 6'd1);
            nxt.bit_count    = 4'd1;
            if (half) begin
               nxt.bit_count  = 4'd0;
               nxt.bytes_left = bl_dec;
               if (bl_dec == 6'd0) begin
                  nxt.phase = PH_STOP_END;
               end else begin
                  nxt.shift_reg = 8'd0;
                  nxt.phase     = PH_RX;
               end
            end
         end

         default: begin
            nxt.phase     = PH_IDLE;
            nxt.bit_count = 4'd0;
         end
      endcase

      res.busy_res = (nxt.phase != PH_IDLE);
   end

endmodule

`default_nettype wire

// ===== sv/i2c_master_register_read_core.sv =====
// I2C master register-read core: one transaction is one SCL half-phase tick.
// A result enters the result register as its transaction leaves the input register.
// Throughput: one transaction per cycle unless stalled; state updates as each one passes.
// Reset (synchronous, active high): sequencer idle, registers at 238, 0 and 1.
// A stalled consumer holds the result register; one more transaction may then wait
// in the input register, after which the input stalls too.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_read_core #(
   parameter int MAX_READ_LEN = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // tick transactions
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic       req_sda_in,
   // bus levels and results
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_scl_out,
   output logic            rsp_sda_pull_low,
   output logic            rsp_data_valid,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_done_res,
   output logic [1:0]      rsp_status,
   output logic            rsp_busy_res,
   // configuration writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import i2cmrr_pkg::*;

   `include "assert_macros.svh"

   cfg_type       cfg;
   seq_state_type state_ff;
   seq_state_type state_in;
   seq_state_type step_nxt;
   result_type    step_res;
   result_type    rsp_ff;

   logic in_valid_ff;
   logic in_valid_in;
   logic in_kind_ff;
   logic in_sda_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic advance;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   i2cmrr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Handshake: the input register moves on whenever the result register can take it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Sequencer logic for the transaction held in the input register.
   i2cmrr_step #(
      .MAX_READ_LEN (MAX_READ_LEN)
   ) u_step (
      .kind   (in_kind_ff),
      .sda_in (in_sda_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .nxt    (step_nxt),
      .res    (step_res)
   );

   assign state_in = advance ? step_nxt : state_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= PH_IDLE;
         state_ff.bit_count     <= 4'd0;
         state_ff.shift_reg     <= 8'd0;
         state_ff.bytes_left    <= 6'd0;
         state_ff.result_status <= ST_OK;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_sda_ff  <= req_sda_in;
      end
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_out      = rsp_ff.scl_out;
   assign rsp_sda_pull_low = rsp_ff.sda_pull_low;
   assign rsp_data_valid   = rsp_ff.data_valid;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_status       = rsp_ff.status;
   assign rsp_busy_res     = rsp_ff.busy_res;

   // A received byte and the end of a transaction never share a result.
   `ASSERT_CLK(a_byte_not_with_done, rsp_valid_ff |-> !(rsp_ff.data_valid && rsp_ff.done_res))
   // A finished transaction reports the bus as no longer busy.
   `ASSERT_CLK(a_done_not_busy, (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.busy_res)
   // A nonzero status appears only with the done flag.
   `ASSERT_CLK(a_status_with_done, (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> rsp_ff.done_res)
   // Reset leaves the sequencer idle with nothing pending.
   `ASSERT_CLK_ALWAYS(a_reset_idle, reset |=> (state_ff.phase == PH_IDLE) && !in_valid_ff && !rsp_valid_ff)

endmodule

`default_nettype wire
